@@ rtl/pulse_period_duty_capture_defines.svh @@
// Assertion helpers shared by the scaler, datapath and controller RTL files of the pulse period/duty capture block.
`ifndef PULSE_PERIOD_DUTY_CAPTURE_DEFINES_SVH
`define PULSE_PERIOD_DUTY_CAPTURE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ppdc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ppdc: next-cycle check failed");

`endif

@@ rtl/ppdc_pkg.sv @@
`default_nettype none

package ppdc_pkg;

	localparam int COUNTER_BITS_DEF = 32;
	localparam int TALLY_W          = 32;
	localparam int TICK_W           = 64;
	localparam int RES_W            = 32;
	localparam int TPS_W            = 23;
	localparam int DIV_CNT_W        = $clog2(RES_W);
	localparam int CFG_ADDR_W       = 3;

	localparam logic [TPS_W-1:0]      TPS_RESET = TPS_W'(97656);
	// largest tick count whose product with 1000 still fits in 64 bits
	localparam logic [TICK_W-1:0]     MS_LIMIT  = 64'd18446744073709551;
	localparam logic [CFG_ADDR_W-1:0] ADDR_TPS  = 3'd0;

	localparam logic [1:0] KIND_START    = 2'd0;
	localparam logic [1:0] KIND_CAPTURE  = 2'd1;
	localparam logic [1:0] KIND_OVERFLOW = 2'd2;

	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_LAST   = 2'd2;
	localparam logic [1:0] PHASE_IDLE   = 2'd3;

	localparam logic [1:0] EDGE_RISING   = 2'd0;
	localparam logic [1:0] EDGE_DISABLED = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_STORE,
		ST_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;   // input transaction accepted
		logic sel;    // 0: period operand, 1: duty operand
		logic ld;     // load operand into the scaler
		logic mul;    // partial product ticks*24, range check
		logic prep;   // ticks*1000, saturation check, divider init
		logic iter;   // one restoring division step
		logic store;  // keep quotient of the selected operand
		logic emit;   // write completed measurement to the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic final_cap;  // current input is the third capture
		logic last;       // division step in progress is the last one
		logic out_free;   // output register can take a new transaction
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/ppdc_scale.sv @@
`default_nettype none
`include "pulse_period_duty_capture_defines.svh"

module ppdc_scale import ppdc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic [TICK_W-1:0] period_ticks,
	input  wire logic [TICK_W-1:0] duty_ticks,
	input  wire logic [TPS_W-1:0]  tps,
	output logic      [RES_W-1:0]  quo,
	output logic                   last
);

	logic [TICK_W-1:0]    op_q;
	logic [TICK_W-1:0]    t24_q;
	logic                 big_q;
	logic                 sat_q;
	logic [TPS_W-1:0]     rem_q;
	logic [RES_W-1:0]     dvd_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [TICK_W-1:0] prod;
	logic [RES_W-1:0]  prod_hi;
	logic [TPS_W:0]    trial;

	// ticks*1000 = ticks*1024 - ticks*24
	assign prod    = (op_q << 10) - t24_q;
	assign prod_hi = prod[TICK_W-1:RES_W];
	assign trial   = {rem_q, dvd_q[RES_W-1]} - {1'b0, tps};
	assign last    = (cnt_q == {DIV_CNT_W{1'b1}});
	assign quo     = sat_q ? {RES_W{1'b1}} : dvd_q;

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			op_q <= cmd.sel ? duty_ticks : period_ticks;
		end
		if (cmd.mul) begin
			t24_q <= (op_q << 4) + (op_q << 3);
			big_q <= (op_q > MS_LIMIT);
		end
		if (cmd.prep) begin
			// quotient >= 2^32 exactly when the upper half reaches the divisor
			sat_q <= (tps == '0) || big_q || (prod_hi >= RES_W'(tps));
			rem_q <= prod_hi[TPS_W-1:0];
			dvd_q <= prod[RES_W-1:0];
		end else if (cmd.iter) begin
			if (!trial[TPS_W]) begin
				rem_q <= trial[TPS_W-1:0];
			end else begin
				rem_q <= {rem_q[TPS_W-2:0], dvd_q[RES_W-1]};
			end
			dvd_q <= {dvd_q[RES_W-2:0], ~trial[TPS_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.prep) begin
			cnt_q <= '0;
		end else if (cmd.iter) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	`PPDC_ASSERT_IMP(a_rem_below_divisor, clk, arst_n, cmd.iter && !sat_q, rem_q < tps)

endmodule

`default_nettype wire

@@ rtl/ppdc_dp.sv @@
`default_nettype none
`include "pulse_period_duty_capture_defines.svh"

module ppdc_dp import ppdc_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire logic [1:0]       kind,
	input  wire logic [31:0]      captured_count,
	input  wire logic [TPS_W-1:0] tps,
	input  wire logic             out_stall,
	output sts_t                  sts,
	output logic                  out_valid,
	output logic                  out_done,
	output logic      [RES_W-1:0] out_period,
	output logic      [RES_W-1:0] out_duty,
	output logic      [1:0]       out_edge
);

	localparam int TS_W = TALLY_W + COUNTER_BITS;

	logic [1:0]         phase_q, phase_d;
	logic               falling_q, falling_d;
	logic [TALLY_W-1:0] tally_q, tally_d;
	logic [TS_W-1:0]    ts0_q, ts1_q;
	logic [TS_W-1:0]    ts_cur;
	logic [1:0]         edge_nxt;

	logic [TICK_W-1:0] period_ticks_q, duty_ticks_q;
	logic [RES_W-1:0]  period_res_q, duty_res_q;
	logic [RES_W-1:0]  quo;
	logic              last;
	logic              out_load;

	// extended timestamp: overflow tally above the raw counter value
	assign ts_cur = {tally_q, captured_count[COUNTER_BITS-1:0]};

	always_comb begin
		phase_d   = phase_q;
		falling_d = falling_q;
		tally_d   = tally_q;
		unique case (kind)
			KIND_START: begin
				phase_d   = PHASE_FIRST;
				falling_d = 1'b0;
				tally_d   = '0;
			end
			KIND_OVERFLOW: begin
				tally_d = tally_q + TALLY_W'(1);
			end
			KIND_CAPTURE: begin
				if (phase_q == PHASE_LAST) begin
					phase_d = PHASE_IDLE;
				end else if (phase_q != PHASE_IDLE) begin
					phase_d   = phase_q + 2'd1;
					falling_d = ~falling_q;
				end
			end
			default: ;
		endcase
	end

	assign edge_nxt      = (phase_d == PHASE_IDLE) ? EDGE_DISABLED : {1'b0, falling_d};
	assign sts.final_cap = (kind == KIND_CAPTURE) && (phase_q == PHASE_LAST);
	assign sts.last      = last;
	assign sts.out_free  = !out_valid || !out_stall;
	assign out_load      = (cmd.take && !sts.final_cap) || cmd.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PHASE_IDLE;
			falling_q <= 1'b0;
			tally_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.take) begin
				phase_q   <= phase_d;
				falling_q <= falling_d;
				tally_q   <= tally_d;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && (kind == KIND_CAPTURE) && (phase_q == PHASE_FIRST)) begin
			ts0_q <= ts_cur;
		end
		if (cmd.take && (kind == KIND_CAPTURE) && (phase_q == PHASE_SECOND)) begin
			ts1_q <= ts_cur;
		end
		if (cmd.take && sts.final_cap) begin
			// high + low collapses to third minus first, modulo 2^64
			period_ticks_q <= TICK_W'(ts_cur) - TICK_W'(ts0_q);
			duty_ticks_q   <= TICK_W'(ts1_q) - TICK_W'(ts0_q);
		end
		if (cmd.store) begin
			if (cmd.sel) begin
				duty_res_q <= quo;
			end else begin
				period_res_q <= quo;
			end
		end
		if (cmd.emit) begin
			out_done   <= 1'b1;
			out_period <= period_res_q;
			out_duty   <= duty_res_q;
			out_edge   <= EDGE_DISABLED;
		end else if (cmd.take && !sts.final_cap) begin
			out_done   <= 1'b0;
			out_period <= '0;
			out_duty   <= '0;
			out_edge   <= edge_nxt;
		end
	end

	ppdc_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.period_ticks (period_ticks_q),
		.duty_ticks   (duty_ticks_q),
		.tps          (tps),
		.quo          (quo),
		.last         (last)
	);

	`PPDC_ASSERT_NEXT(a_emit_result, clk, arst_n, cmd.emit, out_valid && out_done && (out_edge == EDGE_DISABLED))

endmodule

`default_nettype wire

@@ rtl/ppdc_ctrl.sv @@
`default_nettype none
`include "pulse_period_duty_capture_defines.svh"

module ppdc_ctrl import ppdc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire sts_t sts,
	output logic      in_stall,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	logic   sel_q, sel_d;

	// next state
	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.out_free && sts.final_cap) begin
					state_d = ST_LOAD;
					sel_d   = 1'b0;
				end
			end
			ST_LOAD:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_PREP;
			ST_PREP:  state_d = ST_DIV;
			ST_DIV: begin
				if (sts.last) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				if (sel_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_LOAD;
					sel_d   = 1'b1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		cmd.sel  = sel_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = !sts.out_free;
				cmd.take = in_valid && sts.out_free;
			end
			ST_LOAD:  cmd.ld    = 1'b1;
			ST_MUL:   cmd.mul   = 1'b1;
			ST_PREP:  cmd.prep  = 1'b1;
			ST_DIV:   cmd.iter  = 1'b1;
			ST_STORE: cmd.store = 1'b1;
			ST_EMIT:  cmd.emit  = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	`PPDC_ASSERT_NEXT(a_final_starts_period, clk, arst_n, cmd.take && sts.final_cap, (state_q == ST_LOAD) && !sel_q)
	`PPDC_ASSERT_IMP(a_emit_after_duty, clk, arst_n, state_q == ST_EMIT, sel_q)

endmodule

`default_nettype wire

@@ rtl/pulse_period_duty_capture.sv @@
// Pulse period/duty capture. Feed start, capture and counter-overflow transactions from a
// free-running COUNTER_BITS-bit timer; the block extends each capture with a 32-bit overflow
// tally, and the third capture after a start yields period (third minus first capture) and
// duty (second minus first) in milliseconds as floor(ticks * 1000 / ticks_per_second),
// saturated to 32 bits; a zero divisor gives all ones. Every input transaction returns
// exactly one output transaction; edge_armed reports the capture edge now selected (rising,
// falling, or disabled while idle). Start, overflow, ignored captures and the unused kind
// code are registered at the accepting edge, and the next transaction can be taken in the
// following cycle unless the output stalls. The measurement-completing capture keeps the
// input stalled until its result is posted: both results go through one shared scaler, each
// as an operand load, multiply-by-1000 and range checks, a restoring divider that yields one
// quotient bit per cycle, and a store; the result is then posted once the output is free.
// ticks_per_second sits at byte address 0 of the APB port (23 bits, reset 97656); write it
// only while no measurement is in flight. pready is tied high.
`default_nettype none

module pulse_period_duty_capture import ppdc_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// APB configuration
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	// input transactions
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            kind,
	input  wire logic [31:0]           captured_count,
	// output transactions
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       measurement_done,
	output logic      [31:0]           period_ms,
	output logic      [31:0]           duty_ms,
	output logic      [1:0]            edge_armed
);

	logic [TPS_W-1:0] tps_q;
	cmd_t             cmd;
	sts_t             sts;

	// Config register: single divisor; the user must write it only while idle, the block does not enforce this.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_TPS) ? 32'(tps_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (psel && penable && pwrite && (paddr == ADDR_TPS)) begin
			tps_q <= pwdata[TPS_W-1:0];
		end
	end

	// Sequencer: accepts transactions, steps the shared scaler twice per measurement.
	ppdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Capture state, timestamp differences, scaler and output register.
	ppdc_dp #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.kind           (kind),
		.captured_count (captured_count),
		.tps            (tps_q),
		.out_stall      (out_stall),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_done       (measurement_done),
		.out_period     (period_ms),
		.out_duty       (duty_ms),
		.out_edge       (edge_armed)
	);

endmodule

`default_nettype wire
